// ===== src/chained_hash_set_assert.svh =====
// Assertion macros used by the checker file of the hash set.
`ifndef CHAINED_HASH_SET_ASSERT_SVH
`define CHAINED_HASH_SET_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("chained_hash_set: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("chained_hash_set: next-cycle check failed");

`endif

// ===== src/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Types and constants shared by the chained hash set modules.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int KEY_W           = 31;
    localparam int SIZE_W          = 7;
    localparam int BIDX_W          = 6;
    localparam int DEF_NUM_BUCKETS = 64;
    localparam int DEF_CHAIN_DEPTH = 8;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(64);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_LIST   = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [BIDX_W-1:0] bucket_index;
    } t_req;

    typedef struct packed {
        logic             found;
        logic             overflow;
        logic             entry_valid;
        logic [KEY_W-1:0] entry_value;
        logic             last;
    } t_rsp;

endpackage

// ===== src/chained_hash_set.sv =====
// Insert runs the key through the bit-serial modulo unit, reads the bucket count and
// shows its result; search and remove then also walk the chain one entry at a time.
// List skips the modulo unit and shows each entry, or one result if empty or out of range.
// Requests are taken one at a time; busy stays high until the last result is shown.
// Results appear for one cycle on o_strobe; the receiver cannot stall them.
// After reset a clearing pass zeroes every bucket count with busy high.
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set with bounded per-bucket chains held in two synchronous memories.
// ----------------------------------------------------------------------------
module chained_hash_set #(
    parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS,
    parameter int CHAIN_DEPTH = chs_pkg::DEF_CHAIN_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  chs_pkg::t_req              i_req,
    output logic                       busy,
    output logic                       o_strobe,
    output chs_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic [chs_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import chs_pkg::*;

    localparam int BW        = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int PW        = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int CW        = $clog2(CHAIN_DEPTH + 1);
    localparam int ENT_DEPTH = NUM_BUCKETS << PW;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_CREQ  = 7'b0001000,
        S_CRSP  = 7'b0010000,
        S_EREQ  = 7'b0100000,
        S_ERSP  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] eff_size;
    logic [BW-1:0]     r_clr;
    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [BW-1:0]     r_bucket, n_bucket;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_hit, n_hit;
    logic              r_strobe, n_strobe;
    t_rsp              r_rsp, n_rsp;

    logic              mod_start, mod_done;
    logic [SIZE_W-1:0] mod_rem;
    logic [BW+SIZE_W-1:0] rem_ext, bidx_ext;

    logic [CW-1:0]     mem_cnt [NUM_BUCKETS];
    logic [KEY_W-1:0]  mem_ent [ENT_DEPTH];
    logic [CW-1:0]     r_cnt_q;
    logic [KEY_W-1:0]  r_ent_q;
    logic              cnt_we, ent_we;
    logic [BW-1:0]     cnt_waddr;
    logic [CW-1:0]     cnt_wdata;
    logic [BW+PW-1:0]  ent_waddr, ent_raddr;
    logic [KEY_W-1:0]  ent_wdata;
    logic              at_last;

    always_comb begin
        eff_size = r_table_size;
        if (r_table_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (int'(r_table_size) > NUM_BUCKETS) begin
            eff_size = SIZE_W'(NUM_BUCKETS);
        end
    end

    assign rem_ext   = {{BW{1'b0}}, mod_rem};
    assign bidx_ext  = {{(BW + SIZE_W - BIDX_W){1'b0}}, i_req.bucket_index};
    assign ent_raddr = {r_bucket, r_pos[PW-1:0]};
    assign at_last   = ({1'b0, r_pos} + 1'b1) == {1'b0, r_n};

    chs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (i_req.key),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    always_comb begin
        n_state   = r_state;
        n_bucket  = r_bucket;
        n_n       = r_n;
        n_pos     = r_pos;
        n_hit     = r_hit;
        n_strobe  = 1'b0;
        n_rsp     = '0;
        n_rsp.last = 1'b1;
        mod_start = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = r_bucket;
        cnt_wdata = '0;
        ent_we    = 1'b0;
        ent_waddr = ent_raddr;
        ent_wdata = r_key;

        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                if (r_clr == BW'(NUM_BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_pos = '0;
                    n_hit = 1'b0;
                    if (i_req.op == OP_LIST) begin
                        n_bucket = bidx_ext[BW-1:0];
                        if ({1'b0, i_req.bucket_index} >= eff_size) begin
                            n_strobe = 1'b1;
                        end else begin
                            n_state = S_CREQ;
                        end
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_bucket = rem_ext[BW-1:0];
                    n_state  = S_CREQ;
                end
            end
            S_CREQ: begin
                n_state = S_CRSP;
            end
            S_CRSP: begin
                n_n = r_cnt_q;
                if (r_op == OP_INSERT) begin
                    n_state = S_IDLE;
                    n_strobe = 1'b1;
                    if (r_cnt_q >= CW'(CHAIN_DEPTH)) begin
                        n_rsp.overflow = 1'b1;
                    end else begin
                        ent_we    = 1'b1;
                        ent_waddr = {r_bucket, r_cnt_q[PW-1:0]};
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt_q + 1'b1;
                    end
                end else if (r_cnt_q == '0) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_state = S_EREQ;
                end
            end
            S_EREQ: begin
                n_state = S_ERSP;
            end
            S_ERSP: begin
                n_pos   = r_pos + 1'b1;
                n_state = S_EREQ;
                case (r_op)
                    OP_SEARCH: begin
                        if (r_ent_q == r_key || at_last) begin
                            n_state     = S_IDLE;
                            n_strobe    = 1'b1;
                            n_rsp.found = (r_ent_q == r_key);
                        end
                    end
                    OP_REMOVE: begin
                        // Once the match is seen, each later entry moves down one place.
                        if (r_hit) begin
                            ent_we    = 1'b1;
                            ent_waddr = {r_bucket, PW'(r_pos - 1'b1)};
                            ent_wdata = r_ent_q;
                        end
                        if (r_ent_q == r_key) begin
                            n_hit = 1'b1;
                        end
                        if (at_last) begin
                            n_state     = S_IDLE;
                            n_strobe    = 1'b1;
                            n_rsp.found = r_hit || (r_ent_q == r_key);
                            if (r_hit || (r_ent_q == r_key)) begin
                                cnt_we    = 1'b1;
                                cnt_wdata = r_n - 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_strobe          = 1'b1;
                        n_rsp.entry_valid = 1'b1;
                        n_rsp.entry_value = r_ent_q;
                        n_rsp.last        = at_last;
                        if (at_last) begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_table_size <= TABLE_SIZE_RST;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bucket <= n_bucket;
        r_n      <= n_n;
        r_pos    <= n_pos;
        r_hit    <= n_hit;
        r_rsp    <= n_rsp;
        if (r_state == S_IDLE && start) begin
            r_op  <= i_req.op;
            r_key <= i_req.key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            mem_cnt[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= mem_cnt[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            mem_ent[ent_waddr] <= ent_wdata;
        end
        r_ent_q <= mem_ent[ent_raddr];
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ===== src/chs_mod.sv =====
// ----------------------------------------------------------------------------
// chs_mod
// Restoring remainder unit: key modulo table size, one key bit per cycle.
// ----------------------------------------------------------------------------
module chs_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [chs_pkg::KEY_W-1:0]  i_dividend,
    input  logic [chs_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [chs_pkg::SIZE_W-1:0] o_rem
);
    import chs_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_dvs;
    logic [KEY_W-1:0]  r_dvd;
    logic [SIZE_W:0]   n_trial;

    always_comb begin
        n_trial = {r_rem, r_dvd[KEY_W-1]};
        if (n_trial >= {1'b0, r_dvs}) begin
            n_trial = n_trial - {1'b0, r_dvs};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(KEY_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_dvd <= i_dividend;
        end else if (r_run) begin
            r_rem <= n_trial[SIZE_W-1:0];
            r_dvd <= {r_dvd[KEY_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== src/chs_checker.sv =====
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the chained hash set request and result timing.
// ----------------------------------------------------------------------------
`include "chained_hash_set_assert.svh"

module chs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input chs_pkg::t_rsp o_rsp
);
    import chs_pkg::*;

    // An accepted request keeps the block busy, unless it is an out-of-range list
    // whose single result follows at once.
    `CHS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy || o_strobe)
    `CHS_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_rsp.last, !busy)
    `CHS_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_rsp.last, busy && o_rsp.entry_valid)
    `CHS_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_strobe && !o_rsp.last, !o_strobe)

endmodule

bind chained_hash_set chs_checker u_chs_checker (.*);
